// ----- rtl/bmp_pixel_stream_decoder_unit_macros.svh -----
// Assertion macros used by the BMP decoder checker.
`ifndef BMP_PIXEL_STREAM_DECODER_UNIT_MACROS_SVH
`define BMP_PIXEL_STREAM_DECODER_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its antecedent.
`define BMPDEC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define BMPDEC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/bmpdec_pkg.sv -----
// Types, codes and constants of the BMP pixel stream decoder.
package bmpdec_pkg;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_SKIP,
		PH_PIXEL,
		PH_PAD,
		PH_DONE,
		PH_FAULT
	} phase_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_SIGNATURE  = 3'd1,
		ERR_DEPTH      = 3'd2,
		ERR_COMPRESSED = 3'd3,
		ERR_PALETTE    = 3'd4,
		ERR_SIZE       = 3'd5,
		ERR_TRUNCATED  = 3'd6
	} err_code_t;

	typedef enum logic {
		KIND_PIXEL = 1'b0,
		KIND_ERROR = 1'b1
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_end;
	} byte_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [11:0] column;
		logic [11:0] row;
		logic       image_done;
		err_code_t  error_code;
	} result_t;

	localparam logic [15:0] SIGNATURE    = 16'h4d42;
	localparam logic [31:0] HEADER_BYTES = 32'd54;
	localparam logic [15:0] MIN_DEPTH    = 16'd24;
	localparam logic [15:0] MAX_DEPTH    = 16'd64;

	localparam logic [31:0] POS_SIGNATURE   = 32'd1;
	localparam logic [31:0] POS_OFFSET      = 32'd13;
	localparam logic [31:0] POS_WIDTH       = 32'd21;
	localparam logic [31:0] POS_HEIGHT      = 32'd25;
	localparam logic [31:0] POS_DEPTH       = 32'd29;
	localparam logic [31:0] POS_COMPRESSION = 32'd33;
	localparam logic [31:0] POS_COLORS      = 32'd49;
	localparam logic [31:0] POS_LAST        = 32'd53;

	function automatic result_t error_result(input err_code_t code);
		result_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.error_code = code;
		return r;
	endfunction

endpackage

// ----- rtl/bmpdec_byte_if.sv -----
// Byte input channel of the BMP decoder.
interface bmpdec_byte_if;
	logic                    valid;
	logic                    ready;
	bmpdec_pkg::byte_item_t  payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ----- rtl/bmpdec_result_if.sv -----
// Result output channel of the BMP decoder.
interface bmpdec_result_if;
	logic                 valid;
	logic                 ready;
	bmpdec_pkg::result_t  payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ----- rtl/bmpdec_result_buf.sv -----
// Two-entry result buffer that decouples the parser from the output channel.
module bmpdec_result_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	input  bmpdec_pkg::result_t push_data,
	output logic                full,
	bmpdec_result_if.source     result_stream
);

	bmpdec_pkg::result_t head_q;
	bmpdec_pkg::result_t tail_q;
	logic                head_valid_q;
	logic                tail_valid_q;
	logic                pop;

	assign pop                   = head_valid_q && result_stream.ready;
	assign full                  = tail_valid_q;
	assign result_stream.valid   = head_valid_q;
	assign result_stream.payload = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			tail_valid_q <= 1'b0;
		end else begin
			case ({push_valid, pop})
				2'b10: begin
					if (head_valid_q) begin
						tail_valid_q <= 1'b1;
					end else begin
						head_valid_q <= 1'b1;
					end
				end
				2'b01: begin
					head_valid_q <= tail_valid_q;
					tail_valid_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push_valid, pop})
			2'b10: begin
				if (head_valid_q) begin
					tail_q <= push_data;
				end else begin
					head_q <= push_data;
				end
			end
			2'b01: begin
				head_q <= tail_q;
			end
			2'b11: begin
				if (tail_valid_q) begin
					head_q <= tail_q;
					tail_q <= push_data;
				end else begin
					head_q <= push_data;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/bmp_pixel_stream_decoder_unit.sv -----
// Top level of the BMP pixel stream decoder.
//
// byte_stream carries the file one byte per transaction; file_end marks the
// last byte, after which the parser rearms for the next file.
// result_stream carries pixel transactions (color, destination column and
// row, image_done on the final pixel) and error transactions (error_code).
// A byte that yields a result registers it in the result buffer, which drives
// result_stream. One byte is accepted per cycle while byte_stream.ready is high;
// the header field, position and pixel counters all update as it is accepted.
// A two-entry result buffer lets a byte be accepted while one result waits;
// byte_stream.ready drops only while both entries are held by a stalled
// receiver, and nothing is lost or repeated across a stall.
// Reset clears the parser to the start of a header and empties the buffer.
// Bottom-up files have their rows flipped so that row zero is the top row.
module bmp_pixel_stream_decoder_unit #(
	parameter int unsigned MAX_WIDTH  = 4096,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  logic            clk,
	input  logic            arst_n,
	bmpdec_byte_if.sink     byte_stream,
	bmpdec_result_if.source result_stream
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	bmpdec_pkg::phase_t    phase_q, phase_d;
	logic [31:0]           pos_q, pos_d;
	logic [31:0]           shift_q, shift_d;
	logic [31:0]           offset_q, offset_d;
	logic [WW-1:0]         width_q, width_d;
	logic [HW-1:0]         height_q, height_d;
	logic                  top_down_q, top_down_d;
	logic [3:0]            bpp_q, bpp_d;
	logic [2:0]            idx_q, idx_d;
	logic [1:0]            pad_q, pad_d;
	logic [WW-1:0]         col_q, col_d;
	logic [HW-1:0]         row_q, row_d;
	logic [7:0]            blue_q, blue_d;
	logic [7:0]            green_q, green_d;

	logic                  accept;
	logic                  buf_full;
	logic [7:0]            b;
	logic                  fend;
	logic [31:0]           v;
	logic [31:0]           pos_inc;
	logic [15:0]           depth;
	logic [31:0]           mag;
	logic [31:0]           offset_eff;
	logic                  col_last;
	logic                  row_last;
	logic                  final_pix;
	logic [HW-1:0]         drow;
	logic [1:0]            row_prod;
	logic [1:0]            pad_amt;
	logic [1:0]            pad_dec;
	logic                  hdr_err;
	bmpdec_pkg::err_code_t hdr_code;
	logic                  res_valid;
	bmpdec_pkg::result_t   res;
	bmpdec_pkg::result_t   res_pix;

	assign byte_stream.ready = !buf_full;
	assign accept            = byte_stream.valid && byte_stream.ready;
	assign b                 = byte_stream.payload.data_byte;
	assign fend              = byte_stream.payload.file_end;

	assign v          = {b, shift_q[31:8]};
	assign pos_inc    = (&pos_q) ? pos_q : pos_q + 32'd1;
	assign depth      = v[31:16];
	assign mag        = v[31] ? (32'd0 - v) : v;
	assign offset_eff = (offset_q < bmpdec_pkg::HEADER_BYTES) ?
		bmpdec_pkg::HEADER_BYTES : offset_q;

	assign col_last  = ((WW+1)'(col_q) + (WW+1)'(1)) >= (WW+1)'(width_q);
	assign row_last  = ((HW+1)'(row_q) + (HW+1)'(1)) >= (HW+1)'(height_q);
	assign final_pix = col_last && row_last;
	assign drow      = top_down_q ? row_q : (height_q - HW'(1) - row_q);
	assign row_prod  = 2'(width_q) * bpp_q[1:0];
	assign pad_amt   = 2'd0 - row_prod;
	assign pad_dec   = (pad_q != 2'd0) ? pad_q - 2'd1 : 2'd0;

	always_comb begin
		res_pix            = '0;
		res_pix.kind       = bmpdec_pkg::KIND_PIXEL;
		res_pix.red        = b;
		res_pix.green      = green_q;
		res_pix.blue       = blue_q;
		res_pix.column     = 12'(col_q);
		res_pix.row        = 12'(drow);
		res_pix.image_done = final_pix;
		res_pix.error_code = bmpdec_pkg::ERR_NONE;
	end

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		shift_d    = shift_q;
		offset_d   = offset_q;
		width_d    = width_q;
		height_d   = height_q;
		top_down_d = top_down_q;
		bpp_d      = bpp_q;
		idx_d      = idx_q;
		pad_d      = pad_q;
		col_d      = col_q;
		row_d      = row_q;
		blue_d     = blue_q;
		green_d    = green_q;
		hdr_err    = 1'b0;
		hdr_code   = bmpdec_pkg::ERR_NONE;
		res_valid  = 1'b0;
		res        = res_pix;
		if (accept) begin
			case (phase_q)
				bmpdec_pkg::PH_HEADER: begin
					shift_d = v;
					pos_d   = pos_inc;
					case (pos_q)
						bmpdec_pkg::POS_SIGNATURE: begin
							if (v[31:16] != bmpdec_pkg::SIGNATURE) begin
								hdr_code = bmpdec_pkg::ERR_SIGNATURE;
							end
						end
						bmpdec_pkg::POS_OFFSET: begin
							offset_d = v;
						end
						bmpdec_pkg::POS_WIDTH: begin
							if (v[31] || v == 32'd0 || v > 32'(MAX_WIDTH)) begin
								hdr_code = bmpdec_pkg::ERR_SIZE;
							end else begin
								width_d = v[WW-1:0];
							end
						end
						bmpdec_pkg::POS_HEIGHT: begin
							top_down_d = v[31];
							if (mag == 32'd0 || mag > 32'(MAX_HEIGHT)) begin
								hdr_code = bmpdec_pkg::ERR_SIZE;
							end else begin
								height_d = mag[HW-1:0];
							end
						end
						bmpdec_pkg::POS_DEPTH: begin
							if (depth < bmpdec_pkg::MIN_DEPTH || depth > bmpdec_pkg::MAX_DEPTH
								|| depth[2:0] != 3'd0) begin
								hdr_code = bmpdec_pkg::ERR_DEPTH;
							end else begin
								bpp_d = depth[6:3];
							end
						end
						bmpdec_pkg::POS_COMPRESSION: begin
							if (v != 32'd0) begin
								hdr_code = bmpdec_pkg::ERR_COMPRESSED;
							end
						end
						bmpdec_pkg::POS_COLORS: begin
							if (v != 32'd0) begin
								hdr_code = bmpdec_pkg::ERR_PALETTE;
							end
						end
						bmpdec_pkg::POS_LAST: begin
							offset_d = offset_eff;
						end
						default: ;
					endcase
					if (hdr_code != bmpdec_pkg::ERR_NONE) begin
						hdr_err   = 1'b1;
						res_valid = 1'b1;
						res       = bmpdec_pkg::error_result(hdr_code);
						phase_d   = bmpdec_pkg::PH_FAULT;
					end else if (pos_q == bmpdec_pkg::POS_LAST) begin
						phase_d = (pos_inc >= offset_eff) ?
							bmpdec_pkg::PH_PIXEL : bmpdec_pkg::PH_SKIP;
					end
				end
				bmpdec_pkg::PH_SKIP: begin
					pos_d = pos_inc;
					if (pos_inc >= offset_q) begin
						phase_d = bmpdec_pkg::PH_PIXEL;
					end
				end
				bmpdec_pkg::PH_PIXEL: begin
					if (idx_q == 3'd0) begin
						blue_d = b;
					end
					if (idx_q == 3'd1) begin
						green_d = b;
					end
					if (idx_q == 3'd2) begin
						res_valid = 1'b1;
					end
					if (idx_q == 3'd2 && final_pix) begin
						phase_d = bmpdec_pkg::PH_DONE;
					end else if (({1'b0, idx_q} + 4'd1) >= bpp_q) begin
						idx_d = 3'd0;
						if (col_last) begin
							col_d = '0;
							row_d = row_q + HW'(1);
							if (pad_amt != 2'd0) begin
								pad_d   = pad_amt;
								phase_d = bmpdec_pkg::PH_PAD;
							end
						end else begin
							col_d = col_q + WW'(1);
						end
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end
				bmpdec_pkg::PH_PAD: begin
					pad_d = pad_dec;
					if (pad_dec == 2'd0) begin
						phase_d = bmpdec_pkg::PH_PIXEL;
					end
				end
				default: ;
			endcase
			if (fend) begin
				if (!hdr_err && phase_d != bmpdec_pkg::PH_DONE
					&& phase_d != bmpdec_pkg::PH_FAULT) begin
					res_valid = 1'b1;
					res       = bmpdec_pkg::error_result(bmpdec_pkg::ERR_TRUNCATED);
				end
				phase_d = bmpdec_pkg::PH_HEADER;
				pos_d   = '0;
				idx_d   = '0;
				pad_d   = '0;
				col_d   = '0;
				row_d   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bmpdec_pkg::PH_HEADER;
			pos_q   <= '0;
			idx_q   <= '0;
			pad_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			idx_q   <= idx_d;
			pad_q   <= pad_d;
			col_q   <= col_d;
			row_q   <= row_d;
		end
	end

	always_ff @(posedge clk) begin
		shift_q    <= shift_d;
		offset_q   <= offset_d;
		width_q    <= width_d;
		height_q   <= height_d;
		top_down_q <= top_down_d;
		bpp_q      <= bpp_d;
		blue_q     <= blue_d;
		green_q    <= green_d;
	end

	bmpdec_result_buf u_result_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.push_valid    (res_valid),
		.push_data     (res),
		.full          (buf_full),
		.result_stream (result_stream)
	);

endmodule

// ----- rtl/bmpdec_checker.sv -----
// Port-level checker of the BMP decoder and its bind to the top level.
`include "bmp_pixel_stream_decoder_unit_macros.svh"

module bmpdec_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input bmpdec_pkg::result_t out_payload
);

	logic out_stall;
	logic is_error;
	logic is_pixel;
	logic error_clean;

	assign out_stall   = out_valid && !out_ready;
	assign is_error    = out_valid && out_payload.kind == bmpdec_pkg::KIND_ERROR;
	assign is_pixel    = out_valid && out_payload.kind == bmpdec_pkg::KIND_PIXEL;
	assign error_clean = out_payload.red == 8'd0 && out_payload.green == 8'd0
		&& out_payload.blue == 8'd0 && out_payload.column == 12'd0
		&& out_payload.row == 12'd0 && !out_payload.image_done
		&& out_payload.error_code != bmpdec_pkg::ERR_NONE
		&& out_payload.error_code <= bmpdec_pkg::ERR_TRUNCATED;

	`BMPDEC_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_payload), "result not held")

	`BMPDEC_ASSERT_NOW(a_error_clean, is_error, error_clean, "malformed error transaction")

	`BMPDEC_ASSERT_NOW(a_pixel_clean, is_pixel, out_payload.error_code == bmpdec_pkg::ERR_NONE, "bad pixel")

	`BMPDEC_ASSERT_NOW(a_stall_cause, !in_ready, out_valid, "input stalled with no result waiting")

endmodule

bind bmp_pixel_stream_decoder_unit bmpdec_checker u_bmpdec_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (byte_stream.ready),
	.out_valid   (result_stream.valid),
	.out_ready   (result_stream.ready),
	.out_payload (result_stream.payload)
);
